FILE: rtl/rgb_hsv_color_window_classifier_defines.svh
// assertion macros for the classifier rtl
`ifndef RGB_HSV_COLOR_WINDOW_CLASSIFIER_DEFINES_SVH
`define RGB_HSV_COLOR_WINDOW_CLASSIFIER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RHCW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition that must hold on every clock edge outside reset
`define RHCW_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("invariant check failed");

`endif

FILE: rtl/rhcw_pkg.sv
// ----------------------------------------------------------------------------
// rhcw_pkg
// Shared types, widths and helpers of the rgb to hsv color window classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhcw_pkg;

    localparam int PIX_W    = 8;
    localparam int COL_W    = 12;
    localparam int WIN_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CLS_W    = 2;
    localparam int QUO_W    = 8;
    // saturation divide: (510*d + max) / (2*max)
    localparam int SREM_W   = 17;
    localparam int SDIV_W   = 9;
    // hue divide: (510*n + 6*d) / (12*d)
    localparam int HREM_W   = 20;
    localparam int HDIV_W   = 12;

    localparam int DEF_LAST_COLUMN = 640;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 2'd2;

    // class codes
    localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_RED    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_YELLOW = 2'd2;
    localparam logic [CLS_W-1:0] CLS_BLUE   = 2'd3;

    localparam logic [WIN_W-1:0] RST_RED_WIN    = 48'hFF44FF7CFF00;
    localparam logic [WIN_W-1:0] RST_YELLOW_WIN = 48'hFF9EFF443012;
    localparam logic [WIN_W-1:0] RST_BLUE_WIN   = 48'h6A1DFF5AAA47;

    // one pixel moving down the divider row
    typedef struct packed {
        logic [PIX_W-1:0]  val;
        logic [SREM_W-1:0] s_rem;
        logic [SDIV_W-1:0] s_div;
        logic [HREM_W-1:0] h_rem;
        logic [HDIV_W-1:0] h_div;
        logic [QUO_W-1:0]  s_q;
        logic [QUO_W-1:0]  h_q;
    } t_div_slot;

    // low exclusive, high inclusive test on all three components
    function automatic logic in_window(input logic [WIN_W-1:0] w,
                                       input logic [PIX_W-1:0] h,
                                       input logic [PIX_W-1:0] s,
                                       input logic [PIX_W-1:0] v);
        return (h > w[7:0])   && (h <= w[15:8])
            && (s > w[23:16]) && (s <= w[31:24])
            && (v > w[39:32]) && (v <= w[47:40]);
    endfunction

endpackage

FILE: rtl/rgb_hsv_color_window_classifier.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_window_classifier
// Converts BGR pixels to 8-bit HSV and classifies them against three windows.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel transfer happens on a clock edge with start high and busy low.
//   busy is always low: a pixel may be offered on every cycle.
//   Each pixel gives one result, shown for one cycle with o_strobe high,
//   in input order. Throughput is one pixel per cycle. The pipeline is one
//   entry stage, a row of eight divide cells (one quotient bit of hue and
//   saturation each) and one window stage.
//   The receiver cannot stall; results must be taken as they appear.
//   Window registers are written through the cfg channel (always ready),
//   index 0 red, 1 yellow, 2 blue; index 3 is ignored. Write only while no
//   pixel is in flight.
//   Synchronous reset empties the pipeline and loads the default windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hsv_color_window_classifier #(
    parameter int LAST_COLUMN = rhcw_pkg::DEF_LAST_COLUMN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [rhcw_pkg::PIX_W-1:0]       i_blue_level,
    input  logic [rhcw_pkg::PIX_W-1:0]       i_green_level,
    input  logic [rhcw_pkg::PIX_W-1:0]       i_red_level,
    input  logic [rhcw_pkg::COL_W-1:0]       i_column_index,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rhcw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rhcw_pkg::WIN_W-1:0]       i_cfg_data,
    output logic                             o_strobe,
    output logic                             o_mask_bit,
    output logic [rhcw_pkg::CLS_W-1:0]       o_matched_class,
    output logic [rhcw_pkg::PIX_W-1:0]       o_hue_level,
    output logic [rhcw_pkg::PIX_W-1:0]       o_saturation_level,
    output logic [rhcw_pkg::PIX_W-1:0]       o_value_level
);
    import rhcw_pkg::*;
    `include "rgb_hsv_color_window_classifier_defines.svh"

    logic [WIN_W-1:0] r_red_win, r_yellow_win, r_blue_win;
    logic             accept;
    logic             vld [0:QUO_W];
    t_div_slot        slot [0:QUO_W];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_win    <= RST_RED_WIN;
            r_yellow_win <= RST_YELLOW_WIN;
            r_blue_win   <= RST_BLUE_WIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RED:    r_red_win    <= i_cfg_data;
                REG_YELLOW: r_yellow_win <= i_cfg_data;
                REG_BLUE:   r_blue_win   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // entry stage
    rhcw_front #(
        .LAST_COLUMN (LAST_COLUMN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_blue  (i_blue_level),
        .i_green (i_green_level),
        .i_red   (i_red_level),
        .i_col   (i_column_index),
        .o_valid (vld[0]),
        .o_slot  (slot[0])
    );

    // divider row, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rhcw_div_cell #(
            .BIT (QUO_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .i_slot  (slot[k]),
            .o_valid (vld[k+1]),
            .o_slot  (slot[k+1])
        );
    end

    // window test and output register
    rhcw_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (vld[QUO_W]),
        .i_slot       (slot[QUO_W]),
        .i_red_win    (r_red_win),
        .i_yellow_win (r_yellow_win),
        .i_blue_win   (r_blue_win),
        .o_strobe     (o_strobe),
        .o_mask       (o_mask_bit),
        .o_class      (o_matched_class),
        .o_hue        (o_hue_level),
        .o_sat        (o_saturation_level),
        .o_val        (o_value_level)
    );

    // a zero component can never pass a window
    `RHCW_ASSERT_IMPLY(a_val_zero_no_match, o_strobe && (o_value_level == '0), !o_mask_bit)
    `RHCW_ASSERT_IMPLY(a_sat_zero_no_match, o_strobe && (o_saturation_level == '0), !o_mask_bit)
    // gray pixels carry no hue
    `RHCW_ASSERT_IMPLY(a_gray_no_hue, o_strobe && (o_saturation_level == '0), o_hue_level == '0)
    `RHCW_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

FILE: rtl/rhcw_front.sv
// ----------------------------------------------------------------------------
// rhcw_front
// Entry stage: max, min, delta, hue numerator and both divide operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhcw_front #(
    parameter int LAST_COLUMN = rhcw_pkg::DEF_LAST_COLUMN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rhcw_pkg::PIX_W-1:0]    i_blue,
    input  logic [rhcw_pkg::PIX_W-1:0]    i_green,
    input  logic [rhcw_pkg::PIX_W-1:0]    i_red,
    input  logic [rhcw_pkg::COL_W-1:0]    i_col,
    output logic                          o_valid,
    output rhcw_pkg::t_div_slot           o_slot
);
    import rhcw_pkg::*;

    logic [PIX_W-1:0]  mx, mn, dl;
    logic signed [12:0] t0, t1, d6;
    logic [10:0]        nh;
    logic               r_valid;
    t_div_slot          r_slot, n_slot;

    // extremes and delta
    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue  > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue  < mn) mn = i_blue;
        dl = mx - mn;
    end

    // hue numerator over 6*delta, wrapped into [0, 6*delta)
    always_comb begin
        d6 = 13'(dl) * 13'sd6;
        if (mx == i_red) begin
            t0 = 13'(i_green) - 13'(i_blue);
            if (t0 < 0) t0 = t0 + d6;
        end else if (mx == i_green) begin
            t0 = 13'(dl) * 13'sd2 + 13'(i_blue) - 13'(i_red);
        end else begin
            t0 = 13'(dl) * 13'sd4 + 13'(i_red) - 13'(i_green);
        end
        t1 = (t0 >= d6) ? t0 - d6 : t0;
        nh = t1[10:0];
    end

    // divide operands; out-of-line pixels give all-zero results, gray ones zero hue and saturation
    always_comb begin
        n_slot = '0;
        n_slot.s_div = SDIV_W'(1);
        n_slot.h_div = HDIV_W'(1);
        if (i_col <= COL_W'(LAST_COLUMN)) begin
            n_slot.val = mx;
            if (dl != '0) begin
                n_slot.s_rem = SREM_W'(dl) * SREM_W'(510) + SREM_W'(mx);
                n_slot.s_div = {mx, 1'b0};
                n_slot.h_rem = HREM_W'(nh) * HREM_W'(510) + HREM_W'(dl) * HREM_W'(6);
                n_slot.h_div = HDIV_W'(dl) * HDIV_W'(12);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

FILE: rtl/rhcw_div_cell.sv
// ----------------------------------------------------------------------------
// rhcw_div_cell
// One restoring divide step: settles one quotient bit of hue and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhcw_div_cell #(
    parameter int BIT = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhcw_pkg::t_div_slot i_slot,
    output logic                o_valid,
    output rhcw_pkg::t_div_slot o_slot
);
    import rhcw_pkg::*;

    logic [SREM_W-1:0] s_sh;
    logic [HREM_W-1:0] h_sh;
    logic              r_valid;
    t_div_slot         r_slot, n_slot;

    // trial subtract of the shifted divisors
    always_comb begin
        s_sh   = SREM_W'(i_slot.s_div) << BIT;
        h_sh   = HREM_W'(i_slot.h_div) << BIT;
        n_slot = i_slot;
        if (i_slot.s_rem >= s_sh) begin
            n_slot.s_rem    = i_slot.s_rem - s_sh;
            n_slot.s_q[BIT] = 1'b1;
        end
        if (i_slot.h_rem >= h_sh) begin
            n_slot.h_rem    = i_slot.h_rem - h_sh;
            n_slot.h_q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

FILE: rtl/rhcw_window.sv
// ----------------------------------------------------------------------------
// rhcw_window
// Tests red, yellow and blue windows in order and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhcw_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rhcw_pkg::t_div_slot           i_slot,
    input  logic [rhcw_pkg::WIN_W-1:0]    i_red_win,
    input  logic [rhcw_pkg::WIN_W-1:0]    i_yellow_win,
    input  logic [rhcw_pkg::WIN_W-1:0]    i_blue_win,
    output logic                          o_strobe,
    output logic                          o_mask,
    output logic [rhcw_pkg::CLS_W-1:0]    o_class,
    output logic [rhcw_pkg::PIX_W-1:0]    o_hue,
    output logic [rhcw_pkg::PIX_W-1:0]    o_sat,
    output logic [rhcw_pkg::PIX_W-1:0]    o_val
);
    import rhcw_pkg::*;

    logic [CLS_W-1:0] n_class, r_class;
    logic             r_strobe;
    logic [PIX_W-1:0] r_hue, r_sat, r_val;

    // first matching window wins
    always_comb begin
        if (in_window(i_red_win, i_slot.h_q, i_slot.s_q, i_slot.val)) begin
            n_class = CLS_RED;
        end else if (in_window(i_yellow_win, i_slot.h_q, i_slot.s_q, i_slot.val)) begin
            n_class = CLS_YELLOW;
        end else if (in_window(i_blue_win, i_slot.h_q, i_slot.s_q, i_slot.val)) begin
            n_class = CLS_BLUE;
        end else begin
            n_class = CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_class <= n_class;
        r_hue   <= i_slot.h_q;
        r_sat   <= i_slot.s_q;
        r_val   <= i_slot.val;
    end

    assign o_strobe = r_strobe;
    assign o_mask   = (r_class != CLS_NONE);
    assign o_class  = r_class;
    assign o_hue    = r_hue;
    assign o_sat    = r_sat;
    assign o_val    = r_val;

endmodule

FILE: tb/sv/rgb_hsv_color_window_classifier_checker.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_window_classifier_checker
// Watches the pixel, window-write and result ports, predicts HSV values and
// the matched class of every pixel transfer, and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hsv_color_window_classifier_checker #(
    parameter int LAST_COLUMN = rhcw_pkg::DEF_LAST_COLUMN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [rhcw_pkg::PIX_W-1:0]     i_blue_level,
    input  logic [rhcw_pkg::PIX_W-1:0]     i_green_level,
    input  logic [rhcw_pkg::PIX_W-1:0]     i_red_level,
    input  logic [rhcw_pkg::COL_W-1:0]     i_column_index,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rhcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rhcw_pkg::WIN_W-1:0]     i_cfg_data,
    input  logic                           i_strobe,
    input  logic                           i_mask_bit,
    input  logic [rhcw_pkg::CLS_W-1:0]     i_matched_class,
    input  logic [rhcw_pkg::PIX_W-1:0]     i_hue_level,
    input  logic [rhcw_pkg::PIX_W-1:0]     i_saturation_level,
    input  logic [rhcw_pkg::PIX_W-1:0]     i_value_level,
    output int                             o_fail_count,
    output int                             o_pending
);
    import rhcw_pkg::*;

    typedef struct packed {
        logic             mask;
        logic [CLS_W-1:0] cls;
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] sat;
        logic [PIX_W-1:0] val;
    } t_pixel_class;

    logic [WIN_W-1:0] red_win, yellow_win, blue_win;
    t_pixel_class     exp_mem [0:1023];
    int               wr_cnt = 0;
    int               rd_cnt = 0;

    // component test: low exclusive, high inclusive
    function automatic logic hsv_inside(logic [WIN_W-1:0] w, int h, int s, int v);
        return h > w[7:0] && h <= w[15:8] && s > w[23:16] && s <= w[31:24]
            && v > w[39:32] && v <= w[47:40];
    endfunction

    function automatic t_pixel_class classify_pixel(int b, int g, int r, int col);
        t_pixel_class res;
        int mx, mn, d, n, h, s;
        res = '0;
        h = 0;
        s = 0;
        if (col > LAST_COLUMN) return res;
        mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
        mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
        d = mx - mn;
        if (d > 0) begin
            s = (510 * d + mx) / (2 * mx);
            if (mx == r) begin
                n = g - b;
                if (n < 0) n += 6 * d;
            end else if (mx == g) begin
                n = 2 * d + (b - r);
            end else begin
                n = 4 * d + (r - g);
            end
            if (n >= 6 * d) n -= 6 * d;
            h = (510 * n + 6 * d) / (12 * d);
            if (h > 255) h = 255;
            if (s > 255) s = 255;
        end
        if (hsv_inside(red_win, h, s, mx)) res.cls = CLS_RED;
        else if (hsv_inside(yellow_win, h, s, mx)) res.cls = CLS_YELLOW;
        else if (hsv_inside(blue_win, h, s, mx)) res.cls = CLS_BLUE;
        else res.cls = CLS_NONE;
        res.mask = res.cls != CLS_NONE;
        res.hue = h[7:0];
        res.sat = s[7:0];
        res.val = mx[7:0];
        return res;
    endfunction

    assign o_pending = wr_cnt - rd_cnt;

    // window writes, predictions and result compare
    always @(posedge i_clk) begin
        t_pixel_class got, exp_res;
        if (!i_rst_n) begin
            red_win <= RST_RED_WIN;
            yellow_win <= RST_YELLOW_WIN;
            blue_win <= RST_BLUE_WIN;
            wr_cnt <= 0;
            rd_cnt <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RED: begin
                        red_win <= i_cfg_data;
                    end
                    REG_YELLOW: begin
                        yellow_win <= i_cfg_data;
                    end
                    REG_BLUE: begin
                        blue_win <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                exp_mem[wr_cnt[9:0]] <= classify_pixel(i_blue_level, i_green_level,
                                                       i_red_level, i_column_index);
                wr_cnt <= wr_cnt + 1;
            end
            if (i_strobe) begin
                got = {i_mask_bit, i_matched_class, i_hue_level,
                       i_saturation_level, i_value_level};
                if (wr_cnt == rd_cnt) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = exp_mem[rd_cnt[9:0]];
                    rd_cnt <= rd_cnt + 1;
                    if (got !== exp_res) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: exp m=%0d c=%0d h=%0d s=%0d v=%0d,",
                                      " got m=%0d c=%0d h=%0d s=%0d v=%0d"},
                                exp_res.mask, exp_res.cls, exp_res.hue, exp_res.sat,
                                exp_res.val, got.mask, got.cls, got.hue, got.sat,
                                got.val);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/rgb_hsv_color_window_classifier_test.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_window_classifier_test
// Drives directed and random pixels under several window settings with
// random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hsv_color_window_classifier_test;
    import rhcw_pkg::*;

    // index outside the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PIX_W-1:0]     blue_lvl = '0, green_lvl = '0, red_lvl = '0;
    logic [COL_W-1:0]     column = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0]     cfg_data = '0;
    logic                 strobe, mask_bit;
    logic [CLS_W-1:0]     matched_class;
    logic [PIX_W-1:0]     hue_lvl, sat_lvl, val_lvl;
    int                   fail_count, pending;
    logic                 no_idle;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rgb_hsv_color_window_classifier u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_blue_level(blue_lvl), .i_green_level(green_lvl), .i_red_level(red_lvl),
        .i_column_index(column), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .o_strobe(strobe),
        .o_mask_bit(mask_bit), .o_matched_class(matched_class),
        .o_hue_level(hue_lvl), .o_saturation_level(sat_lvl), .o_value_level(val_lvl)
    );

    rgb_hsv_color_window_classifier_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_blue_level(blue_lvl), .i_green_level(green_lvl), .i_red_level(red_lvl),
        .i_column_index(column), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .i_strobe(strobe),
        .i_mask_bit(mask_bit), .i_matched_class(matched_class),
        .i_hue_level(hue_lvl), .i_saturation_level(sat_lvl),
        .i_value_level(val_lvl), .o_fail_count(fail_count), .o_pending(pending)
    );

    // one pixel transfer, with a random gap ahead of it
    task automatic send_pixel(int b, int g, int r, int col);
        while (!no_idle && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        blue_lvl <= b[7:0];
        green_lvl <= g[7:0];
        red_lvl <= r[7:0];
        column <= col[11:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // let the pipeline empty before any window write
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_window(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // window around a random hsv point so that matches happen; at times fully random
    function automatic logic [WIN_W-1:0] rand_window();
        logic [WIN_W-1:0] w;
        int k, lo, hi;
        w = '0;
        for (k = 0; k < 3; k++) begin
            lo = $urandom_range(200);
            hi = lo + $urandom_range(255 - lo);
            w[k*16 +: 8] = lo[7:0];
            w[k*16+8 +: 8] = hi[7:0];
        end
        if ($urandom_range(5) == 0) w = WIN_W'({$urandom, $urandom});
        return w;
    endfunction

    task automatic random_pixels(int count);
        int k, col;
        for (k = 0; k < count; k++) begin
            no_idle = (k >= count / 2) && (k < count / 2 + 40);
            case ($urandom_range(9))
                0: col = 641 + $urandom_range(3454);
                1: col = $urandom_range(639, 641);
                default: col = $urandom_range(640);
            endcase
            if ($urandom_range(7) == 0)
                send_pixel(k, k, k, col);
            else
                send_pixel($urandom_range(255), $urandom_range(255),
                           $urandom_range(255), col);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int phase;
        no_idle = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, gray, equal maxima, column limit
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 640);
        send_pixel(0, 0, 255, 1);
        send_pixel(0, 255, 0, 2);
        send_pixel(255, 0, 0, 3);
        send_pixel(0, 255, 255, 4);
        send_pixel(255, 255, 0, 5);
        send_pixel(255, 0, 255, 6);
        send_pixel(1, 0, 255, 7);
        send_pixel(0, 1, 255, 8);
        send_pixel(128, 128, 128, 9);
        send_pixel(30, 200, 220, 10);
        send_pixel(200, 90, 20, 11);
        send_pixel(10, 20, 200, 641);
        send_pixel(10, 20, 200, 4095);
        send_pixel(0, 0, 1, 12);
        send_pixel(254, 255, 0, 13);
        drain_results();
        // empty and full windows
        write_window(REG_RED, 48'h000000000000);
        write_window(REG_YELLOW, 48'hFFFFFFFFFFFF);
        write_window(REG_BLUE, 48'hFF00FF00FF00);
        write_window(REG_UNUSED, 48'h123456789ABC);
        send_pixel(0, 0, 255, 0);
        send_pixel(255, 0, 0, 1);
        send_pixel(0, 0, 0, 2);
        send_pixel(90, 90, 90, 3);
        drain_results();
        for (phase = 0; phase < 5; phase++) begin
            if (phase == 0) begin
                write_window(REG_RED, RST_RED_WIN);
                write_window(REG_YELLOW, RST_YELLOW_WIN);
                write_window(REG_BLUE, RST_BLUE_WIN);
            end else begin
                write_window(REG_RED, rand_window());
                write_window(REG_YELLOW, rand_window());
                write_window(REG_BLUE, rand_window());
            end
            random_pixels(120);
            drain_results();
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: rgb_hsv_color_window_classifier.f
+incdir+rtl
rtl/rhcw_pkg.sv
rtl/rhcw_front.sv
rtl/rhcw_div_cell.sv
rtl/rhcw_window.sv
rtl/rgb_hsv_color_window_classifier.sv
tb/sv/rgb_hsv_color_window_classifier_checker.sv
tb/sv/rgb_hsv_color_window_classifier_test.sv
